### sv/csu_pkg.sv
`timescale 1ns / 1ps

package csu_pkg;

  // signed 64-bit limits
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  // default fraction bits of the scale factor
  localparam int SCALE_FRAC_BITS_DEF = 16;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOWER = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_UPPER = 2'd1;

  // operation codes of an input item
  typedef enum logic [2:0] {
    OP_BIND   = 3'd0,
    OP_GROW   = 3'd1,
    OP_MOVE   = 3'd2,
    OP_OFFSET = 3'd3,
    OP_PAD    = 3'd4,
    OP_RESIZE = 3'd5,
    OP_SCALE  = 3'd6,
    OP_QUERY  = 3'd7
  } op_t;

  // request to the shared saturating adder
  typedef struct packed {
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic               sub;
  } alu_req_t;

endpackage

### sv/clamped_segment_unit.sv
`timescale 1ns / 1ps

// Clamped segment unit: holds a signed segment (origin, length) kept inside the
// range between the two bound registers, taken in either order.
// Channels: in_* carries one operation item (op, amount, scale_factor, point),
// out_* returns the segment after it plus the inside flag of a query, and
// cfg_* writes the bound registers (index 0 lower, 1 upper; others ignored).
// Everything runs through one saturating 64-bit adder and one 32x32
// multiplier under a small sequencer, so one item is worked on at a time.
// Query finds the end point and finishes; bind/grow/move/offset/resize run
// operate, clamp, room and done; pad adds a length step and a second clamp and
// room (two bind passes); scale multiplies first (four partial products of
// 32x32 bits, two per value, each accumulated and saturated). in_ready rises
// together with out_valid, so the next item is taken only once the result is offered.
// The result sits in an output register; the next item is accepted while it
// waits, and only the final load waits if the receiver stalls.
// Reset (synchronous, rst_n low) clears the segment to zero, sets the bounds
// to the full signed 64-bit range and drops out_valid.
module clamped_segment_unit #(
  parameter int SCALE_FRAC_BITS = csu_pkg::SCALE_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // operation items
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      in_op,
  input  logic signed [63:0]              in_amount,
  input  logic signed [31:0]              in_scale_factor,
  input  logic signed [63:0]              in_point,
  // result items
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [63:0]              out_seg_origin,
  output logic signed [63:0]              out_seg_length,
  output logic                            out_inside_res,
  // bound register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [csu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic signed [63:0]              cfg_data
);

  // doubling limits for pad
  localparam logic signed [63:0] HALF_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] HALF_MIN = 64'shC000_0000_0000_0001;

  typedef enum logic [2:0] {
    S_IDLE, S_OP, S_MUL, S_CLAMP, S_ROOM, S_PADG, S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [2:0]         op_r, op_nxt;
  logic signed [63:0] amount_r, amount_nxt;
  logic signed [63:0] point_r, point_nxt;
  logic signed [63:0] d_r, d_nxt;
  logic [31:0]        um_r, um_nxt;
  logic               fneg_r, fneg_nxt;
  logic signed [63:0] lower_r, lower_nxt;
  logic signed [63:0] upper_r, upper_nxt;
  logic signed [63:0] lo_r, lo_nxt;
  logic signed [63:0] hi_r, hi_nxt;
  logic signed [63:0] origin_r, origin_nxt;
  logic signed [63:0] length_r, length_nxt;
  logic signed [63:0] end_r, end_nxt;
  logic               padg_r, padg_nxt;
  logic [1:0]         mstep_r, mstep_nxt;
  logic               msel_r, msel_nxt;
  logic [63:0]        mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic [63:0]        prod_r, prod_nxt;
  logic [95:0]        acc_r, acc_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [63:0] out_origin_r, out_origin_nxt;
  logic signed [63:0] out_length_r, out_length_nxt;
  logic               out_inside_r, out_inside_nxt;

  csu_pkg::alu_req_t  alu_req;
  logic signed [63:0] alu_res;
  logic [31:0]        mul_a;
  logic [63:0]        mul_p;
  logic [95:0]        q;
  logic signed [63:0] scaled;
  logic               pt_hit;

  csu_sat_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign in_ready       = (state_r == S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_seg_origin = out_origin_r;
  assign out_seg_length = out_length_r;
  assign out_inside_res = out_inside_r;

  // shared 32x32 multiplier over the magnitude halves
  assign mul_a = mstep_r[0] ? mag_r[63:32] : mag_r[31:0];
  assign mul_p = mul_a * um_r;

  // truncate the fraction and saturate by sign
  always_comb begin
    q = acc_r >> SCALE_FRAC_BITS;
    if (neg_r) begin
      if ((|q[95:64]) || (q[63] && (|q[62:0]))) begin
        scaled = csu_pkg::S64_MIN;
      end else begin
        scaled = -q[63:0];
      end
    end else begin
      if (|q[95:63]) begin
        scaled = csu_pkg::S64_MAX;
      end else begin
        scaled = q[63:0];
      end
    end
  end

  // point test against the stored end point
  always_comb begin
    if (length_r > 0) begin
      pt_hit = (point_r >= origin_r) && (point_r <= end_r);
    end else begin
      pt_hit = (point_r <= origin_r) && (point_r >= end_r);
    end
  end

  // operands of the shared adder
  always_comb begin
    alu_req = '0;
    unique case (state_r)
      S_OP: begin
        case (op_r)
          csu_pkg::OP_GROW: begin
            alu_req.a = length_r;
            alu_req.b = amount_r;
          end
          csu_pkg::OP_QUERY: begin
            alu_req.a = origin_r;
            alu_req.b = length_r;
          end
          default: begin
            alu_req.a = origin_r;
            alu_req.b = amount_r;
          end
        endcase
      end
      S_ROOM: begin
        alu_req.a   = (length_r > 0) ? hi_r : lo_r;
        alu_req.b   = origin_r;
        alu_req.sub = 1'b1;
      end
      S_PADG: begin
        alu_req.a   = length_r;
        alu_req.b   = d_r;
        alu_req.sub = 1'b1;
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  // sequencer and datapath next values
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    amount_nxt     = amount_r;
    point_nxt      = point_r;
    d_nxt          = d_r;
    um_nxt         = um_r;
    fneg_nxt       = fneg_r;
    lower_nxt      = lower_r;
    upper_nxt      = upper_r;
    origin_nxt     = origin_r;
    length_nxt     = length_r;
    end_nxt        = end_r;
    padg_nxt       = padg_r;
    mstep_nxt      = mstep_r;
    msel_nxt       = msel_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    prod_nxt       = prod_r;
    acc_nxt        = acc_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_origin_nxt = out_origin_r;
    out_length_nxt = out_length_r;
    out_inside_nxt = out_inside_r;

    // ordered bounds, refreshed every cycle
    lo_nxt = (lower_r < upper_r) ? lower_r : upper_r;
    hi_nxt = (lower_r < upper_r) ? upper_r : lower_r;

    // bound register writes
    if (cfg_valid) begin
      case (cfg_index)
        csu_pkg::CFG_LOWER: lower_nxt = cfg_data;
        csu_pkg::CFG_UPPER: upper_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_op;
          amount_nxt = in_amount;
          point_nxt  = in_point;
          fneg_nxt   = in_scale_factor[31];
          um_nxt     = in_scale_factor[31] ? 32'(-in_scale_factor)
                                           : 32'(in_scale_factor);
          if (in_amount > HALF_MAX) begin
            d_nxt = csu_pkg::S64_MAX;
          end else if (in_amount < HALF_MIN) begin
            d_nxt = csu_pkg::S64_MIN + 64'sd1;
          end else begin
            d_nxt = in_amount <<< 1;
          end
          padg_nxt  = 1'b0;
          state_nxt = S_OP;
        end
      end
      S_OP: begin
        state_nxt = S_CLAMP;
        case (op_r)
          csu_pkg::OP_GROW:   length_nxt = alu_res;
          csu_pkg::OP_MOVE:   origin_nxt = amount_r;
          csu_pkg::OP_OFFSET: origin_nxt = alu_res;
          csu_pkg::OP_PAD:    origin_nxt = alu_res;
          csu_pkg::OP_RESIZE: length_nxt = amount_r;
          csu_pkg::OP_SCALE: begin
            mag_nxt   = origin_r[63] ? 64'(-origin_r) : 64'(origin_r);
            neg_nxt   = origin_r[63] ^ fneg_r;
            mstep_nxt = 2'd0;
            msel_nxt  = 1'b0;
            state_nxt = S_MUL;
          end
          csu_pkg::OP_QUERY: begin
            end_nxt   = alu_res;
            state_nxt = S_DONE;
          end
          default: ;
        endcase
      end
      S_MUL: begin
        mstep_nxt = mstep_r + 2'd1;
        case (mstep_r)
          2'd0: prod_nxt = mul_p;
          2'd1: begin
            acc_nxt  = {32'd0, prod_r};
            prod_nxt = mul_p;
          end
          2'd2: acc_nxt = acc_r + {prod_r, 32'd0};
          default: begin
            if (!msel_r) begin
              origin_nxt = scaled;
              mag_nxt    = length_r[63] ? 64'(-length_r) : 64'(length_r);
              neg_nxt    = length_r[63] ^ fneg_r;
              msel_nxt   = 1'b1;
            end else begin
              length_nxt = scaled;
              msel_nxt   = 1'b0;
              state_nxt  = S_CLAMP;
            end
          end
        endcase
      end
      S_CLAMP: begin
        if (origin_r < lo_r) begin
          origin_nxt = lo_r;
        end else if (origin_r > hi_r) begin
          origin_nxt = hi_r;
        end
        state_nxt = S_ROOM;
      end
      S_ROOM: begin
        if (length_r > 0) begin
          if (length_r > alu_res) begin
            length_nxt = alu_res;
          end
        end else begin
          if (length_r < alu_res) begin
            length_nxt = alu_res;
          end
        end
        if (op_r == csu_pkg::OP_PAD && !padg_r) begin
          padg_nxt  = 1'b1;
          state_nxt = S_PADG;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_PADG: begin
        length_nxt = alu_res;
        state_nxt  = S_CLAMP;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_origin_nxt = origin_r;
          out_length_nxt = length_r;
          out_inside_nxt = (op_r == csu_pkg::OP_QUERY) ? pt_hit : 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    amount_r     <= amount_nxt;
    point_r      <= point_nxt;
    d_r          <= d_nxt;
    um_r         <= um_nxt;
    fneg_r       <= fneg_nxt;
    end_r        <= end_nxt;
    mag_r        <= mag_nxt;
    neg_r        <= neg_nxt;
    prod_r       <= prod_nxt;
    acc_r        <= acc_nxt;
    out_origin_r <= out_origin_nxt;
    out_length_r <= out_length_nxt;
    out_inside_r <= out_inside_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lower_r     <= csu_pkg::S64_MIN;
      upper_r     <= csu_pkg::S64_MAX;
      lo_r        <= csu_pkg::S64_MIN;
      hi_r        <= csu_pkg::S64_MAX;
      origin_r    <= '0;
      length_r    <= '0;
      padg_r      <= 1'b0;
      mstep_r     <= 2'd0;
      msel_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lower_r     <= lower_nxt;
      upper_r     <= upper_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      origin_r    <= origin_nxt;
      length_r    <= length_nxt;
      padg_r      <= padg_nxt;
      mstep_r     <= mstep_nxt;
      msel_r      <= msel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ordered bounds never cross
  a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    lo_r <= hi_r)
    else $error("ordered bounds crossed");

  // origin lies within the bounds once clamped
  a_origin_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOM) |-> (origin_r >= lo_r && origin_r <= hi_r))
    else $error("origin outside bounds after clamp");

  // a result is only loaded from the final step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result loaded outside final step");

  // multiply step counter idles outside the multiply phase
  a_mstep_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_MUL) |-> (mstep_r == 2'd0 && !msel_r))
    else $error("multiply step counter left running");

endmodule

### sv/csu_sat_alu.sv
`timescale 1ns / 1ps

module csu_sat_alu (
  input  csu_pkg::alu_req_t  req,
  output logic signed [63:0] res
);

  logic signed [64:0] a_ext;
  logic signed [64:0] b_ext;
  logic signed [64:0] sum;

  // 65-bit add or subtract, then saturate to 64 bits
  always_comb begin
    a_ext = {req.a[63], req.a};
    b_ext = {req.b[63], req.b};
    sum   = req.sub ? (a_ext - b_ext) : (a_ext + b_ext);
    if (sum[64] != sum[63]) begin
      res = sum[64] ? csu_pkg::S64_MIN : csu_pkg::S64_MAX;
    end else begin
      res = sum[63:0];
    end
  end

endmodule
